FILE: sv/lwfw_pkg.sv
// ----------------------------------------------------------------------------
// lwfw_pkg
// shared constants, register indexes and types of the lcd window frame writer
// ----------------------------------------------------------------------------
package lwfw_pkg;

  // default geometry
  localparam int DEF_SCREEN_WIDTH  = 160;
  localparam int DEF_SCREEN_HEIGHT = 128;
  localparam int DEF_MEM_PIXELS    = 20480;

  // field widths
  localparam int CoordW  = 12;
  localparam int CoordMax = 4095;
  localparam int ByteW   = 8;
  localparam int PixW    = 16;
  localparam int CfgIdxW = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_WINDOW_X      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_WINDOW_Y      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_WINDOW_WIDTH  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_WINDOW_HEIGHT = 3'd3;

  // register reset values
  localparam logic [CoordW-1:0] WIN_X_RST      = 12'd0;
  localparam logic [CoordW-1:0] WIN_Y_RST      = 12'd0;
  localparam logic [CoordW-1:0] WIN_WIDTH_RST  = 12'd160;
  localparam logic [CoordW-1:0] WIN_HEIGHT_RST = 12'd128;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // one access of the graphics ram
  typedef struct packed {
    logic rd;
    logic wr_lo;
    logic wr_hi;
  } gram_cmd_t;

endpackage

FILE: sv/lcd_window_frame_writer.sv
// ----------------------------------------------------------------------------
// lcd_window_frame_writer
// lcd graphics ram filled through a rectangular draw window
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  ----------------------------
//  in        sink       in_valid_i / in_ready_o    req_type_i, data_byte_i
//  out       source     out_valid_o / out_ready_i  pixel_value_o, byte_stored_o
//  cfg       sink       cfg_we_i (no wait)         cfg_idx_i, cfg_wdata_i
//
//  one item per cycle unless a result stalls or the sweep runs; the result of
//  an item is valid in the cycle after acceptance (registered read port of the graphics ram)
//  after reset the ram is swept to zero, one pixel a cycle, over all MEM_PIXELS
//  pixels (20480 by default); in_ready_o stays low during the sweep
//  config writes are taken at any time, also during the sweep
//  while a result waits on out_ready_i, in_ready_o follows out_ready_i
//
// ----------------------------------------------------------------------------
module lcd_window_frame_writer #(
  parameter int SCREEN_WIDTH  = lwfw_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = lwfw_pkg::DEF_SCREEN_HEIGHT,
  parameter int MEM_PIXELS    = lwfw_pkg::DEF_MEM_PIXELS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config port
  input  logic                          cfg_we_i,
  input  logic [lwfw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lwfw_pkg::CoordW-1:0]   cfg_wdata_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [lwfw_pkg::ByteW-1:0]    data_byte_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lwfw_pkg::PixW-1:0]     pixel_value_o,
  output logic                          byte_stored_o
);
  import lwfw_pkg::*;

  localparam int AddrW = (MEM_PIXELS > 1) ? $clog2(MEM_PIXELS) : 1;

  gram_cmd_t        cmd;
  logic [AddrW-1:0] addr;
  logic [PixW-1:0]  rdata;
  logic             busy;
  logic             fire;

  // result stage: valid is control, the rest is payload
  logic out_valid_q, out_valid_d;
  logic pix_ok_q, stored_q;

  // accept whenever the sweep is over and the result slot is free or drains in this cycle
  assign in_ready_o = !busy && (!out_valid_q || out_ready_i);
  assign fire       = in_valid_i && in_ready_o;

  // window position and address of the accepted item
  lwfw_pos #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .MEM_PIXELS    (MEM_PIXELS)
  ) u_pos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .req_type_i  (req_type_i),
    .cmd_o       (cmd),
    .addr_o      (addr)
  );

  // pixel store; the read data register doubles as the result payload
  lwfw_gram #(
    .MEM_PIXELS (MEM_PIXELS)
  ) u_gram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .addr_i  (addr),
    .wdata_i (data_byte_i),
    .rdata_o (rdata),
    .busy_o  (busy)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // flags held with the result; the ram keeps its read data until the next read
  always_ff @(posedge clk_i) begin
    if (fire) begin
      pix_ok_q <= cmd.rd;
      stored_q <= cmd.wr_lo || cmd.wr_hi;
    end
  end

  // writes and off-screen reads show a zero pixel
  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = pix_ok_q ? rdata : '0;
  assign byte_stored_o = stored_q;

endmodule

FILE: sv/lwfw_pos.sv
// ----------------------------------------------------------------------------
// lwfw_pos
// window registers, stream position and pixel address generation
// ----------------------------------------------------------------------------
module lwfw_pos #(
  parameter int SCREEN_WIDTH  = lwfw_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = lwfw_pkg::DEF_SCREEN_HEIGHT,
  parameter int MEM_PIXELS    = lwfw_pkg::DEF_MEM_PIXELS,
  localparam int AddrW        = (MEM_PIXELS > 1) ? $clog2(MEM_PIXELS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lwfw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lwfw_pkg::CoordW-1:0]   cfg_wdata_i,
  input  logic                          fire_i,
  input  logic                          req_type_i,
  output lwfw_pkg::gram_cmd_t           cmd_o,
  output logic [AddrW-1:0]              addr_o
);
  import lwfw_pkg::*;

  localparam int MaxLin = 2 * CoordMax * SCREEN_WIDTH + 2 * CoordMax;
  localparam int LinA   = $clog2(MaxLin + 1);
  localparam int LinB   = $clog2(MEM_PIXELS + 1);
  localparam int LinW   = (LinA > LinB) ? LinA : LinB;

  logic [CoordW-1:0] wx_q, wx_d, wy_q, wy_d, ww_q, ww_d, wh_q, wh_d;
  logic [CoordW-1:0] col_q, col_d, row_q, row_d;
  logic              phase_q, phase_d;
  logic [LinW-1:0]   origin_q, origin_d, row_base_q, row_base_d;

  logic              cfg_hit;
  logic [LinW-1:0]   new_origin;
  logic [LinW-1:0]   lin;
  logic              in_mem, active, rd_ok, advance;
  logic [CoordW:0]   col_nxt, row_nxt;

  // new window registers and origin address of a config write
  always_comb begin
    wx_d    = wx_q;
    wy_d    = wy_q;
    ww_d    = ww_q;
    wh_d    = wh_q;
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW_X: begin
          wx_d    = cfg_wdata_i;
          cfg_hit = 1'b1;
        end
        REG_WINDOW_Y: begin
          wy_d    = cfg_wdata_i;
          cfg_hit = 1'b1;
        end
        REG_WINDOW_WIDTH: begin
          ww_d    = cfg_wdata_i;
          cfg_hit = 1'b1;
        end
        REG_WINDOW_HEIGHT: begin
          wh_d    = cfg_wdata_i;
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
    new_origin = LinW'(wx_d) + LinW'(wy_d) * LinW'(SCREEN_WIDTH);
  end

  assign lin     = row_base_q + LinW'(col_q);
  assign in_mem  = lin < LinW'(MEM_PIXELS);
  assign active  = (ww_q != '0) && (wh_q != '0);
  assign rd_ok   = (wx_q < CoordW'(SCREEN_WIDTH)) && (wy_q < CoordW'(SCREEN_HEIGHT))
                   && (origin_q < LinW'(MEM_PIXELS));
  assign advance = fire_i && (req_type_i == REQ_WRITE) && active;
  assign col_nxt = {1'b0, col_q} + 1'b1;
  assign row_nxt = {1'b0, row_q} + 1'b1;

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    phase_d    = phase_q;
    origin_d   = origin_q;
    row_base_d = row_base_q;
    if (cfg_hit) begin
      col_d      = '0;
      row_d      = '0;
      phase_d    = 1'b0;
      origin_d   = new_origin;
      row_base_d = new_origin;
    end else if (advance) begin
      if (!phase_q) begin
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
        if (col_nxt >= {1'b0, ww_q}) begin
          col_d = '0;
          if (row_nxt >= {1'b0, wh_q}) begin
            row_d      = '0;
            row_base_d = origin_q;
          end else begin
            row_d      = row_nxt[CoordW-1:0];
            row_base_d = row_base_q + LinW'(SCREEN_WIDTH);
          end
        end else begin
          col_d = col_nxt[CoordW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wx_q       <= WIN_X_RST;
      wy_q       <= WIN_Y_RST;
      ww_q       <= WIN_WIDTH_RST;
      wh_q       <= WIN_HEIGHT_RST;
      col_q      <= '0;
      row_q      <= '0;
      phase_q    <= 1'b0;
      origin_q   <= '0;
      row_base_q <= '0;
    end else begin
      wx_q       <= wx_d;
      wy_q       <= wy_d;
      ww_q       <= ww_d;
      wh_q       <= wh_d;
      col_q      <= col_d;
      row_q      <= row_d;
      phase_q    <= phase_d;
      origin_q   <= origin_d;
      row_base_q <= row_base_d;
    end
  end

  always_comb begin
    cmd_o.rd    = fire_i && (req_type_i == REQ_READ) && rd_ok;
    cmd_o.wr_lo = advance && in_mem && !phase_q;
    cmd_o.wr_hi = advance && in_mem && phase_q;
    addr_o      = (req_type_i == REQ_READ) ? origin_q[AddrW-1:0] : lin[AddrW-1:0];
  end

endmodule

FILE: sv/lwfw_gram.sv
// ----------------------------------------------------------------------------
// lwfw_gram
// graphics ram with byte lanes and a clearing sweep after reset
// ----------------------------------------------------------------------------
module lwfw_gram #(
  parameter int MEM_PIXELS = lwfw_pkg::DEF_MEM_PIXELS,
  localparam int AddrW     = (MEM_PIXELS > 1) ? $clog2(MEM_PIXELS) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lwfw_pkg::gram_cmd_t         cmd_i,
  input  logic [AddrW-1:0]            addr_i,
  input  logic [lwfw_pkg::ByteW-1:0]  wdata_i,
  output logic [lwfw_pkg::PixW-1:0]   rdata_o,
  output logic                        busy_o
);
  import lwfw_pkg::*;

  logic [ByteW-1:0] mem_lo [MEM_PIXELS];
  logic [ByteW-1:0] mem_hi [MEM_PIXELS];

  logic             busy_q, busy_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic [PixW-1:0]  rdata_q;
  logic [AddrW-1:0] waddr;
  logic [ByteW-1:0] wbyte;
  logic             we_lo, we_hi;

  always_comb begin
    busy_d     = busy_q;
    clr_addr_d = clr_addr_q;
    if (busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == AddrW'(MEM_PIXELS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      busy_q     <= busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign waddr = busy_q ? clr_addr_q : addr_i;
  assign wbyte = busy_q ? '0 : wdata_i;
  assign we_lo = busy_q || cmd_i.wr_lo;
  assign we_hi = busy_q || cmd_i.wr_hi;

  always_ff @(posedge clk_i) begin
    if (we_lo) begin
      mem_lo[waddr] <= wbyte;
    end
    if (we_hi) begin
      mem_hi[waddr] <= wbyte;
    end
    if (cmd_i.rd) begin
      rdata_q <= {mem_hi[addr_i], mem_lo[addr_i]};
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

FILE: sv/lwfw_checker.sv
// ----------------------------------------------------------------------------
// lwfw_checker
// port-level checks of the lcd window frame writer, bound to the top level
// ----------------------------------------------------------------------------
module lwfw_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [lwfw_pkg::PixW-1:0]   pixel_value_o,
  input logic                        byte_stored_o
);
  import lwfw_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_value_o)
                                    && $stable(byte_stored_o))
    else $error("stalled result changed");

  // every accepted item shows its result in the next cycle
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("result missing one cycle after acceptance");

  // no acceptance while a result is blocked
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o || out_ready_i)
    else $error("item accepted over a blocked result");

  // a stored byte never comes with a nonzero pixel
  a_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_stored_o |-> pixel_value_o == '0)
    else $error("write result carries a pixel");

endmodule

bind lcd_window_frame_writer lwfw_checker u_lwfw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .pixel_value_o (pixel_value_o),
  .byte_stored_o (byte_stored_o)
);

FILE: test/lcd_window_frame_writer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_window_frame_writer_tb
// self-checking bench for the windowed lcd graphics ram writer
// ----------------------------------------------------------------------------
// A scoreboard object keeps its own copy of the graphics ram, the window
// registers and the stream position. It predicts the pixel and store flag
// of every accepted item and checks each result in order. Directed windows
// cover column spill, rows past the end of memory, an off-screen origin and
// an empty window. Random phases then reprogram the window and stream bytes
// and reads, with random idle time on both channels.
// ----------------------------------------------------------------------------
module lcd_window_frame_writer_tb;
  import lwfw_pkg::*;

  localparam int SCR_W       = DEF_SCREEN_WIDTH;
  localparam int SCR_H       = DEF_SCREEN_HEIGHT;
  localparam int GRAM_PIXELS = DEF_MEM_PIXELS;
  localparam int RST_CYCLES  = 9;
  localparam int ITEMS_TOTAL = 1750;
  // the clearing sweep after reset is quiet on both channels and counts toward the limit
  localparam int STALL_LIMIT = 3 * GRAM_PIXELS + 4096;
  localparam logic [CoordW-1:0] COORD_MAX_V = CoordW'(CoordMax);

  // --------------------------------------------------------------------------
  // scoreboard: shadow graphics ram, window registers and stream position
  // --------------------------------------------------------------------------
  class window_gram_scoreboard;
    typedef struct packed {
      logic [PixW-1:0] pixel;
      logic            stored;
    } gram_result_t;

    bit [PixW-1:0] gram [GRAM_PIXELS];
    int unsigned   win_x, win_y, win_w, win_h;
    int unsigned   col_off, row_off;
    bit            hi_byte_next;
    gram_result_t  awaited_results[$];
    int            errors;

    function new();
      foreach (gram[i]) gram[i] = '0;
      win_x  = 32'(WIN_X_RST);
      win_y  = 32'(WIN_Y_RST);
      win_w  = 32'(WIN_WIDTH_RST);
      win_h  = 32'(WIN_HEIGHT_RST);
      errors = 0;
      restart_stream();
    endfunction

    function void restart_stream();
      col_off      = 0;
      row_off      = 0;
      hi_byte_next = 1'b0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CoordW-1:0] val);
      case (idx)
        REG_WINDOW_X:      win_x = 32'(val);
        REG_WINDOW_Y:      win_y = 32'(val);
        REG_WINDOW_WIDTH:  win_w = 32'(val);
        REG_WINDOW_HEIGHT: win_h = 32'(val);
        default:           return;
      endcase
      restart_stream();
    endfunction

    // low byte then high byte, then next pixel of the window, row-major
    function void step_position();
      if (!hi_byte_next) begin
        hi_byte_next = 1'b1;
        return;
      end
      hi_byte_next = 1'b0;
      col_off++;
      if (col_off >= win_w) begin
        col_off = 0;
        row_off++;
        if (row_off >= win_h) row_off = 0;
      end
    endfunction

    function void note_request(logic req, logic [ByteW-1:0] b);
      gram_result_t res;
      int unsigned  addr;
      res = '0;
      if (req == REQ_WRITE) begin
        // empty window: byte ignored, position frozen
        if (win_w != 0 && win_h != 0) begin
          addr = (win_x + col_off) + (win_y + row_off) * SCR_W;
          if (addr < GRAM_PIXELS) begin
            if (hi_byte_next) gram[addr][PixW-1:ByteW] = b;
            else gram[addr][ByteW-1:0] = b;
            res.stored = 1'b1;
          end
          step_position();
        end
      end else if (win_x < SCR_W && win_y < SCR_H) begin
        addr = win_x + win_y * SCR_W;
        if (addr < GRAM_PIXELS) res.pixel = gram[addr];
      end
      awaited_results.push_back(res);
    endfunction

    function void check_response(logic [PixW-1:0] pix, logic stored);
      gram_result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, pixel_value %h byte_stored %b",
                 $time, pix, stored);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      if (pix !== want.pixel) begin
        $display("%0t: pixel_value expected %h actual %h", $time, want.pixel, pix);
        errors++;
      end
      if (stored !== want.stored) begin
        $display("%0t: byte_stored expected %b actual %b", $time, want.stored, stored);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block hookup
  // --------------------------------------------------------------------------
  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CoordW-1:0]   cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic                req_type;
  logic [ByteW-1:0]    data_byte;
  logic                out_valid;
  logic                out_ready;
  logic [PixW-1:0]     pixel_value;
  logic                byte_stored;

  window_gram_scoreboard sb;
  int items_sent;
  int no_gap_items;
  int quiet_cycles = 0;

  lcd_window_frame_writer dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .req_type_i    (req_type),
    .data_byte_i   (data_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .pixel_value_o (pixel_value),
    .byte_stored_o (byte_stored)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // driving helpers, inputs move on the falling edge only
  // --------------------------------------------------------------------------

  function automatic logic [ByteW-1:0] rand_byte();
    return ByteW'($urandom_range(0, 255));
  endfunction

  function automatic logic [CoordW-1:0] rand_coord(input int unsigned lo,
                                                   input int unsigned hi);
    return CoordW'($urandom_range(lo, hi));
  endfunction

  // mostly back to back or short gaps, now and then a long one,
  // and every so often a run of items with no gap at all
  function int next_gap();
    int pick;
    if (no_gap_items > 0) begin
      no_gap_items--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      no_gap_items = $urandom_range(20, 60);
      return 0;
    end
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  // present one item and hold it until the block takes it
  task automatic drive_request(input logic req, input logic [ByteW-1:0] b);
    int gap;
    gap = next_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= req;
    data_byte <= b;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sb.note_request(req, b);
    items_sent++;
  endtask

  // drop valid and let every outstanding result come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(negedge clk);
    // a little margin after the last result
    repeat (2) @(negedge clk);
  endtask

  // one register write per cycle; caller is on a falling edge
  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CoordW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic program_window(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                                input logic [CoordW-1:0] w, input logic [CoordW-1:0] h);
    drain_results();
    write_register(REG_WINDOW_X, x);
    write_register(REG_WINDOW_Y, y);
    write_register(REG_WINDOW_WIDTH, w);
    write_register(REG_WINDOW_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // result side: random back-pressure, long stalls now and then
  // --------------------------------------------------------------------------
  initial begin
    int run;
    int pick;
    bit rdy;
    out_ready = 1'b0;
    run = 0;
    rdy = 1'b0;
    forever begin
      @(negedge clk);
      if (run == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          rdy = 1'b1;
          run = $urandom_range(1, 30);
        end else if (pick < 9) begin
          rdy = 1'b0;
          run = $urandom_range(1, 3);
        end else begin
          rdy = 1'b0;
          run = $urandom_range(10, 40);
        end
      end
      run--;
      out_ready <= rdy;
    end
  end

  // every accepted result goes to the scoreboard, sampled on the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) sb.check_response(pixel_value, byte_stored);
  end

  // watchdog on cycles where neither channel moves an item
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int pick;
    int n;
    logic [CfgIdxW-1:0] idx;
    logic [CoordW-1:0]  val;

    sb           = new();
    items_sent   = 0;
    no_gap_items = 0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_WINDOW_X;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    req_type     = REQ_WRITE;
    data_byte    = '0;

    repeat (RST_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // reset window, full screen at origin: byte order within a pixel
    // (the ram sweep holds off the first item, the handshake covers it)
    drive_request(REQ_WRITE, 8'h00);
    drive_request(REQ_WRITE, 8'hFF);
    drive_request(REQ_READ, 8'h00);
    drive_request(REQ_WRITE, 8'hA5);
    drive_request(REQ_WRITE, 8'h5A);
    drive_request(REQ_READ, 8'hFF);

    // last screen column: second pixel spills into the next row
    program_window(CoordW'(SCR_W - 1), 12'd0, 12'd2, 12'd1);
    repeat (4) drive_request(REQ_WRITE, rand_byte());
    drive_request(REQ_READ, rand_byte());

    // bottom row: second window row falls past the end of the ram
    program_window(12'd0, CoordW'(SCR_H - 1), 12'd1, 12'd2);
    repeat (4) drive_request(REQ_WRITE, rand_byte());
    drive_request(REQ_READ, rand_byte());

    // all registers at their maximum: everything dropped, read gives zero
    program_window(COORD_MAX_V, COORD_MAX_V, COORD_MAX_V, COORD_MAX_V);
    repeat (2) drive_request(REQ_WRITE, rand_byte());
    drive_request(REQ_READ, rand_byte());

    // origin right of the screen: bytes still land, read gives zero
    program_window(CoordW'(SCR_W + 40), 12'd0, 12'd1, 12'd1);
    repeat (2) drive_request(REQ_WRITE, rand_byte());
    drive_request(REQ_READ, rand_byte());

    // empty window, zero width then zero height
    program_window(12'd5, 12'd5, 12'd0, 12'd3);
    drive_request(REQ_WRITE, rand_byte());
    program_window(12'd5, 12'd5, 12'd3, 12'd0);
    drive_request(REQ_WRITE, rand_byte());
    drive_request(REQ_READ, rand_byte());

    // random phases, each a new window setting and a burst of items
    while (items_sent < ITEMS_TOTAL) begin
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
        // small on-screen windows wrap often
        program_window(rand_coord(0, SCR_W - 1), rand_coord(0, SCR_H - 1),
                       rand_coord(1, 8), rand_coord(1, 6));
      end else if (pick < 13) begin
        // near the right and bottom edges: spill and dropped rows
        program_window(rand_coord(SCR_W - 8, SCR_W - 1),
                       rand_coord(SCR_H - 6, SCR_H - 1),
                       rand_coord(1, 12), rand_coord(1, 8));
      end else if (pick < 15) begin
        program_window(rand_coord(0, COORD_MAX_V), rand_coord(0, COORD_MAX_V),
                       rand_coord(0, COORD_MAX_V), rand_coord(0, COORD_MAX_V));
      end else if (pick < 16) begin
        if ($urandom_range(0, 1))
          program_window(rand_coord(0, SCR_W - 1), rand_coord(0, SCR_H - 1),
                         12'd0, rand_coord(1, 6));
        else
          program_window(rand_coord(0, SCR_W - 1), rand_coord(0, SCR_H - 1),
                         rand_coord(1, 8), 12'd0);
      end else if (pick < 17) begin
        program_window(12'd0, 12'd0, COORD_MAX_V, COORD_MAX_V);
      end else if (pick < 18) begin
        program_window(COORD_MAX_V, rand_coord(0, SCR_H - 1), rand_coord(1, 4), 12'd2);
      end else begin
        // rewrite a single register, restarting the stream mid-window;
        // rarely an index with no register behind it
        drain_results();
        if ($urandom_range(0, 7) == 0) begin
          idx = CfgIdxW'(REG_WINDOW_HEIGHT + 1 + $urandom_range(0, 3));
          val = rand_coord(0, COORD_MAX_V);
        end else begin
          idx = CfgIdxW'($urandom_range(REG_WINDOW_X, REG_WINDOW_HEIGHT));
          if (idx == REG_WINDOW_WIDTH || idx == REG_WINDOW_HEIGHT)
            val = rand_coord(1, 8);
          else
            val = rand_coord(0, SCR_H - 1);
        end
        write_register(idx, val);
        cfg_we <= 1'b0;
      end

      n = $urandom_range(40, 160);
      repeat (n) begin
        if ($urandom_range(0, 7) == 0)
          drive_request(REQ_READ, rand_byte());
        else
          drive_request(REQ_WRITE, rand_byte());
      end
    end

    // wait out the last results, then watch for strays
    drain_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
